[design/fsr_pkg.sv]
// ----------------------------------------------------------------------------
// fsr_pkg
// Shared widths, register indexes, rate codes and helper functions of the
// foveated shading-rate map generator.
// ----------------------------------------------------------------------------
package fsr_pkg;

    // payload widths
    localparam int TEXEL_W     = 10;
    localparam int LAYER_W     = 2;
    localparam int DIM_W       = 11;
    localparam int LC_W        = 3;
    localparam int RADIUS_W    = 16;
    localparam int CODE_W      = 4;
    localparam int INDEX_W     = 22;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LAYER_COUNT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_RADIUS_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_RADIUS_Y = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_AXIS_RADIUS  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_AXIS_RADIUS = 3'd6;

    // register reset values
    localparam logic [DIM_W-1:0]    RST_MAP_WIDTH   = 11'd1;
    localparam logic [DIM_W-1:0]    RST_MAP_HEIGHT  = 11'd1;
    localparam logic [LC_W-1:0]     RST_LAYER_COUNT = 3'd1;
    localparam logic [RADIUS_W-1:0] RST_CENTER_R    = 16'd2048;
    localparam logic [RADIUS_W-1:0] RST_ON_AXIS_R   = 16'd4096;
    localparam logic [RADIUS_W-1:0] RST_OFF_AXIS_R  = 16'd2048;

    // limits on the map geometry
    localparam logic [DIM_W-1:0] MAX_DIM    = 11'd1024;
    localparam logic [LC_W-1:0]  MAX_LAYERS = 3'd4;
    localparam logic [LC_W-1:0]  LC_STEREO  = 3'd2;

    // per-axis rate codes
    localparam logic [1:0] RATE_1 = 2'd0;
    localparam logic [1:0] RATE_2 = 2'd1;
    localparam logic [1:0] RATE_4 = 2'd2;

    // uv arithmetic
    localparam int UV_QBITS           = 18;
    localparam int DIV_W              = 12;
    localparam int DIV_BITS_PER_STAGE = 3;
    localparam int DIV_STAGES         = UV_QBITS / DIV_BITS_PER_STAGE;
    localparam int NUM_W              = 29;
    localparam int UV_W               = 21;
    localparam int MAG_W              = 18;
    localparam int PROD_W             = 34;
    localparam int HALF_W             = 17;
    localparam int SQ_W               = 68;
    localparam int SUM_W              = 69;
    localparam int CMP_W              = 72;
    localparam int RPROD_W            = 32;
    localparam int RHALF_W            = 16;
    localparam int RSQ_W              = 64;

    localparam logic signed [UV_W-1:0] UV_MIN      = -21'sd131072;
    localparam logic signed [UV_W-1:0] UV_MAX      = 21'sd131071;
    localparam logic signed [UV_W-1:0] LAYER_SHIFT = 21'sd655;

    typedef struct packed {
        logic [DIV_W-1:0]    rem;
        logic [UV_QBITS-1:0] nlow;
        logic [UV_QBITS-1:0] quo;
        logic                ovf;
        logic                neg;
    } div_lane_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = {{(DIM_W-1){1'b0}}, 1'b1};
        else if (v > MAX_DIM)
            r = MAX_DIM;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [LC_W-1:0] clamp_layers(input logic [LC_W-1:0] v);
        logic [LC_W-1:0] r;
        if (v == '0)
            r = {{(LC_W-1){1'b0}}, 1'b1};
        else if (v > MAX_LAYERS)
            r = MAX_LAYERS;
        else
            r = v;
        return r;
    endfunction

    // DIV_BITS_PER_STAGE restoring-division steps, one quotient bit each
    function automatic div_lane_t div_steps(input div_lane_t lane_in,
                                            input logic [DIV_W-1:0] divisor);
        div_lane_t      l;
        logic [DIV_W:0] t;
        logic           b;
        l = lane_in;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++)
        begin
            t = {l.rem, l.nlow[UV_QBITS-1]};
            b = (t >= {1'b0, divisor});
            if (b)
                t = t - {1'b0, divisor};
            l.rem  = t[DIV_W-1:0];
            l.nlow = {l.nlow[UV_QBITS-2:0], 1'b0};
            l.quo  = {l.quo[UV_QBITS-2:0], b};
        end
        return l;
    endfunction

endpackage

[design/fsr_texel_if.sv]
// ----------------------------------------------------------------------------
// fsr_texel_if
// Texel request channel: one texel coordinate per beat.
// ----------------------------------------------------------------------------
interface fsr_texel_if
    import fsr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TEXEL_W-1:0] texel_x;
    logic [TEXEL_W-1:0] texel_y;
    logic [LAYER_W-1:0] layer_index;

    modport source (output valid, output texel_x, output texel_y, output layer_index,
                    input ready);
    modport sink   (input valid, input texel_x, input texel_y, input layer_index,
                    output ready);
endinterface

[design/fsr_rate_if.sv]
// ----------------------------------------------------------------------------
// fsr_rate_if
// Result channel: rate code and linear buffer index per beat.
// ----------------------------------------------------------------------------
interface fsr_rate_if
    import fsr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CODE_W-1:0]  rate_code;
    logic [INDEX_W-1:0] buffer_index;

    modport source (output valid, output rate_code, output buffer_index, input ready);
    modport sink   (input valid, input rate_code, input buffer_index, output ready);
endinterface

[design/fsr_cfg_if.sv]
// ----------------------------------------------------------------------------
// fsr_cfg_if
// Register write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface fsr_cfg_if
    import fsr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/foveated_shading_rate_map_top.sv]
// ----------------------------------------------------------------------------
// foveated_shading_rate_map_top
// Shading-rate map texel generator: rate code and buffer index per texel.
// ----------------------------------------------------------------------------
// Takes one texel beat per clock while no beat is parked in the skid buffer.
// The path is a 15-stage pipeline: an input register, a preparation stage,
// six stages of an 18-bit restoring divide (three quotient bits per stage)
// that form uv, an offset stage, a saturation stage, and five stages of split
// multiplies and wide compares for the three ellipse tests, then an output
// register backed by a one-beat skid buffer, so texel ready never depends on
// result ready combinationally. Register writes are taken every cycle; the
// ellipse bounds derived from the radii settle through rp_reg, the split
// products and rsq_reg before any newly accepted texel needs them.
module foveated_shading_rate_map_top
    import fsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    fsr_texel_if.sink          texel,
    fsr_rate_if.source         rate,
    fsr_cfg_if.sink            cfg
);

    localparam int ST_PREP     = 1;
    localparam int ST_DIV_LAST = ST_PREP + DIV_STAGES;
    localparam int ST_OFFSET   = ST_DIV_LAST + 1;
    localparam int ST_SAT      = ST_OFFSET + 1;
    localparam int ST_PROD     = ST_SAT + 1;
    localparam int ST_PART     = ST_PROD + 1;
    localparam int ST_SQ       = ST_PART + 1;
    localparam int ST_SUM      = ST_SQ + 1;
    localparam int ST_CMP      = ST_SUM + 1;
    localparam int NSTAGE      = ST_CMP + 1;
    localparam int IDX_FIRST   = 3;

    // configuration registers
    logic [DIM_W-1:0]    map_width_reg;
    logic [DIM_W-1:0]    map_height_reg;
    logic [LC_W-1:0]     layer_count_reg;
    logic [RADIUS_W-1:0] center_radius_x_reg;
    logic [RADIUS_W-1:0] center_radius_y_reg;
    logic [RADIUS_W-1:0] on_axis_radius_reg;
    logic [RADIUS_W-1:0] off_axis_radius_reg;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [LC_W-1:0]  lc_eff;
    logic [DIV_W-1:0] div_x;
    logic [DIV_W-1:0] div_y;

    // ellipse bounds derived from the radii (0 central, 1 outer)
    logic [RPROD_W-1:0] rp_reg    [2];
    logic [RPROD_W-1:0] rp_hh_reg [2];
    logic [RPROD_W-1:0] rp_hl_reg [2];
    logic [RPROD_W-1:0] rp_ll_reg [2];
    logic [RSQ_W-1:0]   rsq_reg   [2];

    // pipeline
    logic                en;
    logic [NSTAGE-1:0]   valid_reg;
    logic [TEXEL_W-1:0]  x_reg;
    logic [TEXEL_W-1:0]  y_reg;
    logic [LAYER_W-1:0]  layer_reg [ST_DIV_LAST+1];
    logic [21:0]         yw_reg;
    logic [21:0]         wh_reg;
    logic [TEXEL_W-1:0]  x1_reg;
    logic [INDEX_W-1:0]  lwh_reg;
    logic [INDEX_W-1:0]  ywx_reg;
    logic [INDEX_W-1:0]  idx_reg   [IDX_FIRST:ST_CMP];
    div_lane_t           lanex_reg [ST_PREP:ST_DIV_LAST];
    div_lane_t           laney_reg [ST_PREP:ST_DIV_LAST];
    logic signed [UV_W-1:0] usx_reg;
    logic signed [UV_W-1:0] usy_reg;
    logic [MAG_W-1:0]    ax_reg;
    logic [MAG_W-1:0]    ay_reg;
    logic [PROD_W-1:0]   prod_reg [6];
    logic [PROD_W-1:0]   hh_reg   [6];
    logic [PROD_W-1:0]   hl_reg   [6];
    logic [PROD_W-1:0]   ll_reg   [6];
    logic [SQ_W-1:0]     sq_reg   [6];
    logic [SUM_W-1:0]    sum_reg  [3];
    logic [CODE_W-1:0]   code_reg;

    div_lane_t              lanex_next;
    div_lane_t              laney_next;
    logic signed [UV_W-1:0] usx_next;
    logic signed [UV_W-1:0] usy_next;
    logic [MAG_W-1:0]       ax_next;
    logic [MAG_W-1:0]       ay_next;
    logic [CODE_W-1:0]      code_next;

    // output register and skid
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CODE_W-1:0]  out_code_reg;
    logic [INDEX_W-1:0] out_idx_reg;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    logic [CODE_W-1:0]  skid_code_reg;
    logic [INDEX_W-1:0] skid_idx_reg;
    logic               load_out_pipe;
    logic               load_out_skid;
    logic               load_skid;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg       <= RST_MAP_WIDTH;
            map_height_reg      <= RST_MAP_HEIGHT;
            layer_count_reg     <= RST_LAYER_COUNT;
            center_radius_x_reg <= RST_CENTER_R;
            center_radius_y_reg <= RST_CENTER_R;
            on_axis_radius_reg  <= RST_ON_AXIS_R;
            off_axis_radius_reg <= RST_OFF_AXIS_R;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_MAP_WIDTH:       map_width_reg       <= cfg.data[DIM_W-1:0];
                REG_MAP_HEIGHT:      map_height_reg      <= cfg.data[DIM_W-1:0];
                REG_LAYER_COUNT:     layer_count_reg     <= cfg.data[LC_W-1:0];
                REG_CENTER_RADIUS_X: center_radius_x_reg <= cfg.data;
                REG_CENTER_RADIUS_Y: center_radius_y_reg <= cfg.data;
                REG_ON_AXIS_RADIUS:  on_axis_radius_reg  <= cfg.data;
                REG_OFF_AXIS_RADIUS: off_axis_radius_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign w_eff  = clamp_dim(map_width_reg);
    assign h_eff  = clamp_dim(map_height_reg);
    assign lc_eff = clamp_layers(layer_count_reg);
    assign div_x  = {w_eff, 1'b0};
    assign div_y  = {h_eff, 1'b0};

    // radius product squared, in halves so no multiply exceeds 16x16
    always_ff @(posedge clk)
    begin
        rp_reg[0] <= RPROD_W'(center_radius_x_reg) * RPROD_W'(center_radius_y_reg);
        rp_reg[1] <= RPROD_W'(on_axis_radius_reg) * RPROD_W'(off_axis_radius_reg);
        for (int i = 0; i < 2; i++)
        begin
            rp_hh_reg[i] <= RPROD_W'(rp_reg[i][RPROD_W-1:RHALF_W])
                          * RPROD_W'(rp_reg[i][RPROD_W-1:RHALF_W]);
            rp_hl_reg[i] <= RPROD_W'(rp_reg[i][RPROD_W-1:RHALF_W])
                          * RPROD_W'(rp_reg[i][RHALF_W-1:0]);
            rp_ll_reg[i] <= RPROD_W'(rp_reg[i][RHALF_W-1:0])
                          * RPROD_W'(rp_reg[i][RHALF_W-1:0]);
            rsq_reg[i]   <= {rp_hh_reg[i], {RPROD_W{1'b0}}}
                          + {{(RSQ_W-RPROD_W-RHALF_W-1){1'b0}}, rp_hl_reg[i],
                             {(RHALF_W+1){1'b0}}}
                          + {{(RSQ_W-RPROD_W){1'b0}}, rp_ll_reg[i]};
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    assign en          = !skid_valid_reg;
    assign texel.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NSTAGE-2:0], texel.valid};
    end

    // ------------------------------------------------------------------
    // stage logic
    // ------------------------------------------------------------------
    // preparation: numerator |2c - s| * 2^17 + s, divisor 2s, rounds to nearest
    function automatic div_lane_t prep_lane(input logic [TEXEL_W-1:0] c,
                                            input logic [DIM_W-1:0]   s,
                                            input logic [DIV_W-1:0]   dv);
        logic signed [DIV_W-1:0] d;
        logic [DIM_W-1:0]        mag;
        logic [NUM_W-1:0]        num;
        div_lane_t               l;
        d   = $signed({1'b0, c, 1'b0}) - $signed({1'b0, s});
        mag = d[DIV_W-1] ? DIM_W'(-d) : DIM_W'(d);
        num = {1'b0, mag, {HALF_W{1'b0}}} + NUM_W'(s);
        l.rem  = {1'b0, num[NUM_W-1:UV_QBITS]};
        l.nlow = num[UV_QBITS-1:0];
        l.quo  = '0;
        l.ovf  = ({1'b0, num[NUM_W-1:UV_QBITS]} >= dv);
        l.neg  = d[DIV_W-1];
        return l;
    endfunction

    function automatic logic signed [UV_W-1:0] signed_uv(input div_lane_t l);
        logic [UV_QBITS-1:0]    q;
        logic signed [UV_W-1:0] qs;
        q  = l.ovf ? {UV_QBITS{1'b1}} : l.quo;
        qs = $signed({{(UV_W-UV_QBITS){1'b0}}, q});
        return l.neg ? -qs : qs;
    endfunction

    function automatic logic [MAG_W-1:0] sat_mag(input logic signed [UV_W-1:0] v);
        logic signed [UV_W-1:0] s;
        logic signed [UV_W-1:0] a;
        if (v < UV_MIN)
            s = UV_MIN;
        else if (v > UV_MAX)
            s = UV_MAX;
        else
            s = v;
        a = (s < 0) ? -s : s;
        return a[MAG_W-1:0];
    endfunction

    logic signed [UV_W-1:0] layer_off;

    always_comb
    begin
        lanex_next = prep_lane(x_reg, w_eff, div_x);
        laney_next = prep_lane(y_reg, h_eff, div_y);

        if (lc_eff == LC_STEREO)
            layer_off = (layer_reg[ST_DIV_LAST] == '0) ? -LAYER_SHIFT : LAYER_SHIFT;
        else
            layer_off = '0;
        usx_next = signed_uv(lanex_reg[ST_DIV_LAST]) + layer_off;
        usy_next = signed_uv(laney_reg[ST_DIV_LAST]);

        ax_next = sat_mag(usx_reg);
        ay_next = sat_mag(usy_reg);
    end

    // ellipse compares and rate decode
    logic in_c;
    logic in_x;
    logic in_y;

    always_comb
    begin
        in_c = (center_radius_x_reg != '0) && (center_radius_y_reg != '0)
            && ({{(CMP_W-SUM_W){1'b0}}, sum_reg[0]} < {rsq_reg[0], 8'b0});
        in_x = (on_axis_radius_reg != '0) && (off_axis_radius_reg != '0)
            && ({{(CMP_W-SUM_W){1'b0}}, sum_reg[1]} < {rsq_reg[1], 8'b0});
        in_y = (on_axis_radius_reg != '0) && (off_axis_radius_reg != '0)
            && ({{(CMP_W-SUM_W){1'b0}}, sum_reg[2]} < {rsq_reg[1], 8'b0});
        if (in_c)
            code_next = {RATE_1, RATE_1};
        else if (!in_x && !in_y)
            code_next = {RATE_4, RATE_4};
        else
            code_next = {(in_y ? RATE_2 : RATE_1), (in_x ? RATE_2 : RATE_1)};
    end

    // ------------------------------------------------------------------
    // stage registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg        <= texel.texel_x;
            y_reg        <= texel.texel_y;
            layer_reg[0] <= texel.layer_index;
            for (int k = 1; k <= ST_DIV_LAST; k++)
                layer_reg[k] <= layer_reg[k-1];

            // buffer index: layer*w*h + y*w + x
            yw_reg  <= 22'(y_reg) * 22'(w_eff);
            wh_reg  <= 22'(w_eff) * 22'(h_eff);
            x1_reg  <= x_reg;
            lwh_reg <= INDEX_W'(layer_reg[ST_PREP]) * wh_reg;
            ywx_reg <= yw_reg + INDEX_W'(x1_reg);
            idx_reg[IDX_FIRST] <= lwh_reg + ywx_reg;
            for (int k = IDX_FIRST + 1; k <= ST_CMP; k++)
                idx_reg[k] <= idx_reg[k-1];

            // uv divide
            lanex_reg[ST_PREP] <= lanex_next;
            laney_reg[ST_PREP] <= laney_next;
            for (int k = ST_PREP + 1; k <= ST_DIV_LAST; k++)
            begin
                lanex_reg[k] <= div_steps(lanex_reg[k-1], div_x);
                laney_reg[k] <= div_steps(laney_reg[k-1], div_y);
            end

            usx_reg <= usx_next;
            usy_reg <= usy_next;
            ax_reg  <= ax_next;
            ay_reg  <= ay_next;

            // |u| * r for the three ellipses
            prod_reg[0] <= PROD_W'(ax_reg) * PROD_W'(center_radius_y_reg);
            prod_reg[1] <= PROD_W'(ay_reg) * PROD_W'(center_radius_x_reg);
            prod_reg[2] <= PROD_W'(ax_reg) * PROD_W'(off_axis_radius_reg);
            prod_reg[3] <= PROD_W'(ay_reg) * PROD_W'(on_axis_radius_reg);
            prod_reg[4] <= PROD_W'(ax_reg) * PROD_W'(on_axis_radius_reg);
            prod_reg[5] <= PROD_W'(ay_reg) * PROD_W'(off_axis_radius_reg);

            // squares split into 17-bit halves
            for (int i = 0; i < 6; i++)
            begin
                hh_reg[i] <= PROD_W'(prod_reg[i][PROD_W-1:HALF_W])
                           * PROD_W'(prod_reg[i][PROD_W-1:HALF_W]);
                hl_reg[i] <= PROD_W'(prod_reg[i][PROD_W-1:HALF_W])
                           * PROD_W'(prod_reg[i][HALF_W-1:0]);
                ll_reg[i] <= PROD_W'(prod_reg[i][HALF_W-1:0])
                           * PROD_W'(prod_reg[i][HALF_W-1:0]);
                sq_reg[i] <= {hh_reg[i], {PROD_W{1'b0}}}
                           + {{(SQ_W-PROD_W-HALF_W-1){1'b0}}, hl_reg[i],
                              {(HALF_W+1){1'b0}}}
                           + {{(SQ_W-PROD_W){1'b0}}, ll_reg[i]};
            end
            for (int i = 0; i < 3; i++)
                sum_reg[i] <= {1'b0, sq_reg[2*i]} + {1'b0, sq_reg[2*i+1]};

            code_reg <= code_next;
        end
    end

    // ------------------------------------------------------------------
    // output register with skid
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_pipe   = 1'b0;
        load_out_skid   = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (rate.ready)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
                load_out_skid   = 1'b1;
            end
        end
        else if (!out_valid_reg || rate.ready)
        begin
            out_valid_next = valid_reg[ST_CMP];
            load_out_pipe  = 1'b1;
        end
        else if (valid_reg[ST_CMP])
        begin
            // output held: park the beat leaving the pipeline
            skid_valid_next = 1'b1;
            load_skid       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_skid)
        begin
            out_code_reg <= skid_code_reg;
            out_idx_reg  <= skid_idx_reg;
        end
        else if (load_out_pipe)
        begin
            out_code_reg <= code_reg;
            out_idx_reg  <= idx_reg[ST_CMP];
        end
        if (load_skid)
        begin
            skid_code_reg <= code_reg;
            skid_idx_reg  <= idx_reg[ST_CMP];
        end
    end

    assign rate.valid        = out_valid_reg;
    assign rate.rate_code    = out_code_reg;
    assign rate.buffer_index = out_idx_reg;

endmodule
